>>> sv/gf2_quadratic_gray_enumerator_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the GF(2) quadratic Gray-code enumerator
// Shared forms of the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GF2_QUADRATIC_GRAY_ENUMERATOR_DEFINES_SVH
`define GF2_QUADRATIC_GRAY_ENUMERATOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define GQGE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define GQGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Implication that is checked during reset as well.
`define GQGE_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/gqge_pkg.sv
// ---------------------------------------------------------------------------
// gqge_pkg
// Types, codes and helper functions shared by the Gray-code enumerator.
// ---------------------------------------------------------------------------
package gqge_pkg;

	localparam int WORD_W   = 32;
	localparam int IDX_W    = 4;
	localparam int MODE_W   = 3;
	localparam int CNT_W    = 16;
	localparam int PAR_W    = 17;
	localparam int SOL_W    = 32;
	localparam int REG_W    = 5;
	localparam int PFX_W    = 16;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	// Input item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD_QUAD  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_LIN   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_CONST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_START      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STEP       = 3'd4;

	// Commands handed from the front end to the execution unit.
	localparam logic [2:0] OP_LOAD_QUAD  = 3'd0;
	localparam logic [2:0] OP_LOAD_LIN   = 3'd1;
	localparam logic [2:0] OP_LOAD_CONST = 3'd2;
	localparam logic [2:0] OP_START      = 3'd3;
	localparam logic [2:0] OP_STEP       = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_INNER_COUNT  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OUTER_COUNT  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_VALUE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [WORD_W-1:0] word;
	} in_t;

	typedef struct packed {
		logic             hit;
		logic [SOL_W-1:0] solution;
		logic [PAR_W-1:0] parity_vector;
		logic             pass_end;
	} out_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [WORD_W-1:0] word;
	} cmd_t;

	// Configuration as the execution unit sees it, already clamped.
	typedef struct packed {
		logic [REG_W-1:0] n1;
		logic [REG_W-1:0] outer;
		logic [PFX_W-1:0] prefix;
	} cfg_t;

	// Index of the lowest set bit; zero for an all-zero word.
	function automatic logic [IDX_W-1:0] low_index(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] iso;
		logic [IDX_W-1:0] idx;
		iso = v & (~v + 16'd1);
		idx = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (iso[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> sv/gqge_front.sv
// ---------------------------------------------------------------------------
// gqge_front
// Holds the configuration registers, accepts input items, drops the ones
// that cause nothing and turns the rest into commands for the queue.
// ---------------------------------------------------------------------------
module gqge_front #(
	parameter int MAX_INNER = 16,
	parameter int MAX_OUTER = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gqge_pkg::in_t                       in_item,
	input  logic                                cfg_we,
	input  logic [gqge_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [gqge_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output gqge_pkg::cfg_t                      cfg,
	output logic                                push,
	output gqge_pkg::cmd_t                      push_cmd,
	input  logic                                full
);
	import gqge_pkg::*;

	localparam int D1_DEPTH = (MAX_INNER < 16) ? MAX_INNER : 16;
	// Both the inner-count clamp and the index range check use this limit.
	localparam logic [REG_W-1:0] INNER_LIM = REG_W'(D1_DEPTH);
	localparam logic [REG_W-1:0] OUTER_LIM = REG_W'((MAX_OUTER < 31) ? MAX_OUTER : 31);

	logic [REG_W-1:0] inner_q;
	logic [REG_W-1:0] outer_q;
	logic [PFX_W-1:0] prefix_q;
	logic [REG_W-1:0] inner_wr;
	logic [REG_W-1:0] outer_wr;
	logic             accept;
	logic             row_ok;
	logic             col_ok;

	always_comb begin
		inner_wr = cfg_wdata[REG_W-1:0];
		if (inner_wr == '0) begin
			inner_wr = REG_W'(1);
		end else if (inner_wr > INNER_LIM) begin
			inner_wr = INNER_LIM;
		end
		outer_wr = cfg_wdata[REG_W-1:0];
		if (outer_wr > OUTER_LIM) begin
			outer_wr = OUTER_LIM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q  <= INNER_LIM;
			outer_q  <= '0;
			prefix_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INNER_COUNT:  inner_q  <= inner_wr;
				REG_OUTER_COUNT:  outer_q  <= outer_wr;
				REG_PREFIX_VALUE: prefix_q <= cfg_wdata[PFX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.n1     = inner_q;
	assign cfg.outer  = outer_q;
	assign cfg.prefix = prefix_q;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign row_ok   = {1'b0, in_item.row} < INNER_LIM;
	assign col_ok   = {1'b0, in_item.col} < INNER_LIM;

	always_comb begin
		push_cmd.op   = OP_STEP;
		push_cmd.row  = in_item.row;
		push_cmd.col  = in_item.col;
		push_cmd.word = in_item.word;
		push          = 1'b0;
		case (in_item.mode)
			MODE_LOAD_QUAD: begin
				push_cmd.op = OP_LOAD_QUAD;
				push        = accept && row_ok && col_ok;
			end
			MODE_LOAD_LIN: begin
				push_cmd.op = OP_LOAD_LIN;
				push        = accept && row_ok;
			end
			MODE_LOAD_CONST: begin
				push_cmd.op = OP_LOAD_CONST;
				push        = accept;
			end
			MODE_START: begin
				push_cmd.op = OP_START;
				push        = accept;
			end
			MODE_STEP: begin
				push_cmd.op = OP_STEP;
				push        = accept;
			end
			default: ;
		endcase
	end

endmodule

>>> sv/gqge_fifo.sv
// ---------------------------------------------------------------------------
// gqge_fifo
// Short command queue between the front end and the execution unit.
// ---------------------------------------------------------------------------
module gqge_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gqge_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output gqge_pkg::cmd_t  head
);
	import gqge_pkg::*;

	cmd_t                 entry_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign full  = count_q == CMD_CNT_W'(CMD_FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/gqge_back.sv
// ---------------------------------------------------------------------------
// gqge_back
// Execution unit: derivative memories, value word, point counter, parity
// accumulator, the step sequencer with its end-of-pass correction, and the
// output register.
// ---------------------------------------------------------------------------
module gqge_back #(
	parameter int EQ_WIDTH  = 32,
	parameter int MAX_INNER = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gqge_pkg::cfg_t  cfg,
	input  logic            empty,
	input  gqge_pkg::cmd_t  head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output gqge_pkg::out_t  out_item
);
	import gqge_pkg::*;

	localparam int D1_DEPTH = (MAX_INNER < 16) ? MAX_INNER : 16;
	localparam int D2_DEPTH = D1_DEPTH * D1_DEPTH;
	localparam int IW       = $clog2(D1_DEPTH);
	localparam int AW       = $clog2(D2_DEPTH);
	localparam int CW       = (EQ_WIDTH < WORD_W) ? EQ_WIDTH : WORD_W;
	localparam logic [REG_W-1:0] IDX_LIM = REG_W'(D1_DEPTH);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EXEC     = 3'd1;
	localparam logic [2:0] ST_CORR     = 3'd2;
	localparam logic [2:0] ST_FIN_RD   = 3'd3;
	localparam logic [2:0] ST_FIN_EXEC = 3'd4;

	function automatic logic [AW-1:0] d2_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		logic [7:0] t;
		t = 8'(r) * 8'(D1_DEPTH) + 8'(c);
		return t[AW-1:0];
	endfunction

	function automatic logic [SOL_W-1:0] sol_of(input logic [CNT_W-1:0] c,
			input logic [REG_W-1:0] sh, input logic [PFX_W-1:0] pfx);
		logic [CNT_W-1:0] gray;
		logic [PFX_W-1:0] pmask;
		gray = c ^ (c >> 1);
		for (int j = 0; j < PFX_W; j++) begin
			pmask[j] = REG_W'(j) < sh;
		end
		return (SOL_W'(gray) << sh) | SOL_W'(pfx & pmask);
	endfunction

	// Derivative memories.
	logic [EQ_WIDTH-1:0] d1_mem [D1_DEPTH];
	logic [EQ_WIDTH-1:0] d2_mem [D2_DEPTH];
	logic [EQ_WIDTH-1:0] d1_rd_q;
	logic [EQ_WIDTH-1:0] d2_rd_q;
	logic                d1_re;
	logic [IW-1:0]       d1_raddr;
	logic                d1_we;
	logic [IW-1:0]       d1_waddr;
	logic [EQ_WIDTH-1:0] d1_wdata;
	logic                d2_re;
	logic [AW-1:0]       d2_raddr;
	logic                d2_we;

	// Control and walk state.
	logic [2:0]          state_q;
	logic [CNT_W-1:0]    counter_q;
	logic [PAR_W-1:0]    parity_q;
	logic [EQ_WIDTH-1:0] value_q;
	logic                out_valid_q;
	out_t                out_item_q;

	// Step in flight.
	logic [CNT_W-1:0]    c_s1;
	logic [IW-1:0]       k1_s1;
	logic                k1_ok_s1;
	logic                quad_ok_s1;

	// End-of-pass correction.
	logic [IW-1:0]       corr_i_q;
	logic                corr_wr_s1;
	logic [IW-1:0]       corr_idx_s1;

	logic [EQ_WIDTH-1:0] word_ext;
	logic [CNT_W-1:0]    c_next;
	logic [CNT_W-1:0]    c_rest;
	logic [IDX_W-1:0]    k1;
	logic [IDX_W-1:0]    k2;
	logic [REG_W-1:0]    top5;
	logic [IW-1:0]       top_i;
	logic [IW-1:0]       fin_col;
	logic                out_free;
	logic                is_step;
	logic                start_fire;
	logic                exec_fire;
	logic [EQ_WIDTH-1:0] nd1;
	logic [EQ_WIDTH-1:0] nv;
	logic                hit_step;
	logic                end_step;
	logic [CNT_W-1:0]    last_pt;
	logic [CNT_W-1:0]    gray_s1;
	logic [PAR_W-1:0]    start_mask;
	logic [PAR_W-1:0]    par_start;
	logic [PAR_W-1:0]    par_step;
	out_t                res;

	assign word_ext = EQ_WIDTH'(head.word[CW-1:0]);
	assign out_free = !out_valid_q || !out_stall;

	assign pop = (state_q == ST_IDLE) && !empty && ((head.op != OP_START) || out_free);
	assign is_step    = pop && (head.op == OP_STEP);
	assign start_fire = pop && (head.op == OP_START);
	assign exec_fire  = (state_q == ST_EXEC) && out_free;

	// Lowest and next-lowest set bits of the advanced counter.
	assign c_next = counter_q + 16'd1;
	assign c_rest = c_next & (c_next - 16'd1);
	assign k1     = low_index(c_next);
	assign k2     = low_index(c_rest);

	assign top5    = cfg.n1 - 5'd1;
	assign top_i   = top5[IW-1:0];
	assign fin_col = (top_i == '0) ? '0 : top_i - 1'b1;

	always_comb begin
		d1_re    = 1'b0;
		d1_raddr = top_i;
		d2_re    = 1'b0;
		d2_raddr = d2_addr(top_i, fin_col);
		case (state_q)
			ST_IDLE: begin
				d1_re    = is_step;
				d1_raddr = k1[IW-1:0];
				d2_re    = is_step;
				d2_raddr = d2_addr(k2[IW-1:0], k1[IW-1:0]);
			end
			ST_CORR: begin
				d1_re    = 1'b1;
				d1_raddr = corr_i_q;
				d2_re    = 1'b1;
				d2_raddr = d2_addr(top_i, corr_i_q);
			end
			ST_FIN_RD: begin
				d1_re = 1'b1;
				d2_re = 1'b1;
			end
			default: ;
		endcase
	end

	// Step arithmetic on the registered memory words.
	assign nd1      = d1_rd_q ^ (quad_ok_s1 ? d2_rd_q : '0);
	assign nv       = k1_ok_s1 ? (value_q ^ nd1) : value_q;
	assign hit_step = nv == '0;
	assign last_pt  = CNT_W'((17'd1 << cfg.n1) - 17'd1);
	assign end_step = c_s1 >= last_pt;
	assign gray_s1  = c_s1 ^ (c_s1 >> 1);

	always_comb begin
		for (int j = 0; j < PAR_W; j++) begin
			start_mask[j] = REG_W'(j) <= cfg.n1;
		end
	end

	// A step hit toggles bit 0 and, per inner variable at zero, the bit above it.
	assign par_start = (value_q == '0) ? start_mask : '0;
	assign par_step  = hit_step ? (parity_q ^ (start_mask & {~gray_s1, 1'b1})) : parity_q;

	always_comb begin
		d1_we    = 1'b0;
		d1_waddr = head.row[IW-1:0];
		d1_wdata = word_ext;
		if (corr_wr_s1) begin
			d1_we    = 1'b1;
			d1_waddr = corr_idx_s1;
			d1_wdata = d1_rd_q ^ d2_rd_q;
		end else if (exec_fire && k1_ok_s1) begin
			d1_we    = 1'b1;
			d1_waddr = k1_s1;
			d1_wdata = nd1;
		end else if (pop && (head.op == OP_LOAD_LIN)) begin
			d1_we = 1'b1;
		end
	end

	assign d2_we = pop && (head.op == OP_LOAD_QUAD);

	always_ff @(posedge clk) begin
		if (d1_we) begin
			d1_mem[d1_waddr] <= d1_wdata;
		end
		if (d1_re) begin
			d1_rd_q <= d1_mem[d1_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (d2_we) begin
			d2_mem[d2_addr(head.row[IW-1:0], head.col[IW-1:0])] <= word_ext;
		end
		if (d2_re) begin
			d2_rd_q <= d2_mem[d2_raddr];
		end
	end

	always_comb begin
		res.hit           = value_q == '0;
		res.solution      = sol_of(counter_q, cfg.outer, cfg.prefix);
		res.parity_vector = par_start;
		res.pass_end      = 1'b0;
		if (state_q == ST_EXEC) begin
			res.hit           = hit_step;
			res.solution      = sol_of(c_s1, cfg.outer, cfg.prefix);
			res.parity_vector = par_step;
			res.pass_end      = end_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			counter_q   <= '0;
			parity_q    <= '0;
			out_valid_q <= 1'b0;
			corr_wr_s1  <= 1'b0;
		end else begin
			corr_wr_s1 <= state_q == ST_CORR;
			if (start_fire || exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (start_fire) begin
				parity_q <= par_start;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_step) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						parity_q  <= par_step;
						counter_q <= end_step ? '0 : c_s1;
						if (!end_step) begin
							state_q <= ST_IDLE;
						end else if (top_i == '0) begin
							state_q <= ST_FIN_RD;
						end else begin
							state_q <= ST_CORR;
						end
					end
				end
				ST_CORR: begin
					if (corr_i_q == top_i - 1'b1) begin
						state_q <= ST_FIN_RD;
					end
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN_EXEC;
				end
				ST_FIN_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == OP_LOAD_CONST)) begin
			value_q <= word_ext;
		end else if (exec_fire) begin
			value_q <= nv;
		end else if (state_q == ST_FIN_EXEC) begin
			value_q <= value_q ^ d1_rd_q ^ d2_rd_q;
		end
		if (is_step) begin
			c_s1       <= c_next;
			k1_s1      <= k1[IW-1:0];
			k1_ok_s1   <= (c_next != '0) && ({1'b0, k1} < IDX_LIM);
			quad_ok_s1 <= (c_rest != '0) && ({1'b0, k2} < IDX_LIM);
		end
		if (exec_fire) begin
			corr_i_q <= '0;
		end else if (state_q == ST_CORR) begin
			corr_i_q <= corr_i_q + 1'b1;
		end
		corr_idx_s1 <= corr_i_q;
		if (start_fire || exec_fire) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

>>> sv/gf2_quadratic_gray_enumerator.sv
// ---------------------------------------------------------------------------
// gf2_quadratic_gray_enumerator
// Gray-code walker for exhaustive search over a bitsliced system of quadratic
// equations over GF(2). Load, start and step items enter a four-entry command
// queue, so input is taken while the execution unit works or a result waits.
// A step reads the two derivative memories into registers and then applies
// the XOR update once the output register is free. A step that ends a pass
// then runs a correction sweep over the first-derivative words below the top
// one, followed by one read and one update for the value word. Start and step
// give one result item each; loads and unused modes give none.
// ---------------------------------------------------------------------------
module gf2_quadratic_gray_enumerator #(
	parameter int EQ_WIDTH  = 32,
	parameter int MAX_INNER = 16,
	parameter int MAX_OUTER = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gqge_pkg::in_t                       in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gqge_pkg::out_t                      out_item,
	input  logic                                cfg_we,
	input  logic [gqge_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [gqge_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import gqge_pkg::*;

	cfg_t cfg;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic empty;
	cmd_t head;

	gqge_front #(
		.MAX_INNER (MAX_INNER),
		.MAX_OUTER (MAX_OUTER)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	gqge_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	gqge_back #(
		.EQ_WIDTH  (EQ_WIDTH),
		.MAX_INNER (MAX_INNER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

>>> sv/gqge_checker.sv
// ---------------------------------------------------------------------------
// gqge_checker
// Port-level checks on the enumerator's result channel, bound to the top.
// ---------------------------------------------------------------------------
`include "gf2_quadratic_gray_enumerator_defines.svh"

module gqge_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input gqge_pkg::in_t   in_item,
	input logic            out_valid,
	input logic            out_stall,
	input gqge_pkg::out_t  out_item
);
	import gqge_pkg::*;

	logic             in_res;
	logic             out_acc;
	logic [3:0]       pending_q;
	logic [PAR_W-1:0] last_par_q;
	logic             seen_q;

	// Accepted items that will produce a result.
	assign in_res  = in_valid && !in_stall
		&& ((in_item.mode == MODE_START) || (in_item.mode == MODE_STEP));
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			last_par_q <= '0;
			seen_q     <= 1'b0;
		end else begin
			if (in_res && !out_acc) begin
				pending_q <= pending_q + 1'b1;
			end else if (out_acc && !in_res) begin
				pending_q <= pending_q - 1'b1;
			end
			if (out_acc) begin
				last_par_q <= out_item.parity_vector;
				seen_q     <= 1'b1;
			end
		end
	end

	`GQGE_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n, !out_valid, "result shown during reset")

	`GQGE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

	`GQGE_ASSERT_IMPLY(a_no_extra_result, clk, arst_n, out_valid, pending_q != '0, "result without a start or step item")

	// A miss keeps the parity of the previous result, or a start clears it.
	`GQGE_ASSERT_IMPLY(a_miss_parity, clk, arst_n, out_valid && !out_item.hit && seen_q, (out_item.parity_vector == last_par_q) || (out_item.parity_vector == '0), "parity changed without a hit")

endmodule

bind gf2_quadratic_gray_enumerator gqge_checker u_gqge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GF(2) quadratic Gray-code enumerator. It loads
// derivative and value words, runs whole and partial passes over small
// systems, and mixes in stray loads, restarts and unused modes. A behavioral
// copy of the Gray walk predicts each result item, and every result item is
// compared field by field as it leaves the block.
// ---------------------------------------------------------------------------
module tb_top;
	import gqge_pkg::*;

	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET   = 1100;
	localparam int CALM_ITEMS    = 150;

	// Modes the block ignores.
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b1;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_t                   in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	gf2_quadratic_gray_enumerator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// Behavioral copy of the walker state and its registers.
	logic [WORD_W-1:0] model_value;
	logic [WORD_W-1:0] model_d1 [16];
	logic [WORD_W-1:0] model_d2 [16][16];
	logic [CNT_W-1:0]  model_count  = '0;
	logic [PAR_W-1:0]  model_parity = '0;
	logic [REG_W-1:0]  reg_inner    = 5'd16;
	logic [REG_W-1:0]  reg_outer    = '0;
	logic [PFX_W-1:0]  reg_prefix   = '0;

	in_t  stimulus_items[$];
	out_t expected_points[$];

	int errors        = 0;
	int counted_items = 0;
	int plan_vars     = 16;
	int plan_last     = 65535;
	int plan_count    = 0;
	int send_gap      = 0;
	int hold_left     = 0;
	bit in_taken      = 1'b0;
	bit calm          = 1'b0;
	bit bursty_in     = 1'b1;
	bit bursty_out    = 1'b1;
	bit sparse        = 1'b0;
	logic [WORD_W-1:0] word_mask = '1;

	initial forever #5 clk = ~clk;

	function automatic int inner_vars();
		if (reg_inner == '0) return 1;
		if (reg_inner > 5'd16) return 16;
		return int'(reg_inner);
	endfunction

	function automatic int outer_vars();
		return (reg_outer > 5'd16) ? 16 : int'(reg_outer);
	endfunction

	function automatic int lowest_one(input logic [CNT_W-1:0] v);
		for (int i = 0; i < CNT_W; i++) begin
			if (v[i]) return i;
		end
		return 0;
	endfunction

	// Applies one accepted item to the model and queues the result it causes.
	function automatic void advance_walk(input in_t it);
		int n1;
		int top;
		int k1;
		logic [CNT_W-1:0] c;
		logic [CNT_W-1:0] rest;
		logic [CNT_W-1:0] gray;
		logic [CNT_W:0]   last;
		logic [63:0]      sol;
		out_t res;
		bit emits;
		n1 = inner_vars();
		emits = 1'b0;
		res = '0;
		c = '0;
		case (it.mode)
		MODE_LOAD_QUAD: model_d2[it.row][it.col] = it.word;
		MODE_LOAD_LIN: model_d1[it.row] = it.word;
		MODE_LOAD_CONST: model_value = it.word;
		MODE_START: begin
			emits = 1'b1;
			c = model_count;
			res.hit = (model_value == '0);
			model_parity = res.hit ? PAR_W'((32'd1 << (n1 + 1)) - 32'd1) : '0;
		end
		MODE_STEP: begin
			emits = 1'b1;
			last = (17'd1 << n1) - 17'd1;
			c = model_count + 1'b1;
			model_count = c;
			if (c != '0) begin
				k1 = lowest_one(c);
				rest = c & (c - 1'b1);
				if (rest != '0) model_d1[k1] ^= model_d2[lowest_one(rest)][k1];
				model_value ^= model_d1[k1];
			end
			res.hit = (model_value == '0);
			if (res.hit) begin
				gray = c ^ (c >> 1);
				model_parity[0] = ~model_parity[0];
				for (int p = 0; p < n1; p++) begin
					if (!gray[p]) model_parity[p + 1] = ~model_parity[p + 1];
				end
			end
			res.pass_end = ({1'b0, c} >= last);
		end
		default: ;
		endcase
		if (emits) begin
			gray = c ^ (c >> 1);
			sol = (64'(gray) << outer_vars())
				| (64'(reg_prefix) & ((64'd1 << outer_vars()) - 64'd1));
			res.solution = sol[SOL_W-1:0];
			res.parity_vector = model_parity;
			expected_points.push_back(res);
			// The pass correction follows the report of the last point.
			if (res.pass_end) begin
				top = n1 - 1;
				for (int i = 0; i < top; i++) model_d1[i] ^= model_d2[top][i];
				model_value ^= model_d1[top] ^ model_d2[top][(n1 >= 2) ? n1 - 2 : 0];
				model_count = '0;
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_points.size() == 0) begin
					$error("result item with no prediction waiting: %p", out_item);
					errors++;
				end else begin
					want = expected_points.pop_front();
					check_field("hit", want.hit, out_item.hit);
					check_field("solution", want.solution, out_item.solution);
					check_field("parity_vector", want.parity_vector, out_item.parity_vector);
					check_field("pass_end", want.pass_end, out_item.pass_end);
				end
			end
			if (in_valid && !in_stall) begin
				advance_walk(in_item);
				in_taken = 1'b1;
			end
		end
	end

	always @(negedge clk) begin : driver
		bit was_taken;
		was_taken = in_taken;
		in_taken = 1'b0;
		if (was_taken) void'(stimulus_items.pop_front());
		if (arst_n && !(in_valid && !was_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (stimulus_items.size() != 0 && bursty_in && !calm
					&& $urandom_range(9, 0) == 0) begin
				send_gap = $urandom_range(14, 1) - 1;
				in_valid <= 1'b0;
			end else if (stimulus_items.size() != 0) begin
				in_valid <= 1'b1;
				in_item <= stimulus_items[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : sink
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (arst_n && bursty_out && !calm && $urandom_range(9, 0) == 0) begin
			hold_left = $urandom_range(14, 1) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [IDX_W-1:0] rand_idx();
		return IDX_W'($urandom_range(15, 0));
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return $urandom & word_mask;
	endfunction

	// Queues one item and tracks where the point counter will stand.
	function automatic void push_item(input logic [MODE_W-1:0] mode,
			input logic [IDX_W-1:0] row, col, input logic [WORD_W-1:0] word);
		in_t it;
		it.mode = mode;
		it.row = row;
		it.col = col;
		it.word = word;
		stimulus_items.push_back(it);
		if (mode <= MODE_STEP) counted_items++;
		if (mode == MODE_STEP) begin
			plan_count++;
			if (plan_count >= plan_last) plan_count = 0;
		end
	endfunction

	// Writes every word that a pass over n variables can read.
	function automatic void reload_system(input int n);
		for (int r = 0; r < n; r++) begin
			push_item(MODE_LOAD_LIN, IDX_W'(r), rand_idx(), rand_word());
			for (int c = 0; c < r; c++) push_item(MODE_LOAD_QUAD, IDX_W'(r), IDX_W'(c), rand_word());
		end
		push_item(MODE_LOAD_QUAD, '0, '0, rand_word());
		push_item(MODE_LOAD_CONST, rand_idx(), rand_idx(), rand_word());
	endfunction

	function automatic void stray_item();
		case ($urandom_range(4, 0))
		0: push_item(MODE_LOAD_QUAD, rand_idx(), rand_idx(), rand_word());
		1: push_item(MODE_LOAD_LIN, rand_idx(), rand_idx(), rand_word());
		2: push_item(MODE_LOAD_CONST, rand_idx(), rand_idx(), rand_word());
		3: push_item(MODE_START, rand_idx(), rand_idx(), $urandom);
		default: push_item(MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)),
			rand_idx(), rand_idx(), $urandom);
		endcase
	endfunction

	function automatic void run_pass(input bit whole);
		int steps;
		repeat ($urandom_range(2, 0)) stray_item();
		push_item(MODE_START, rand_idx(), rand_idx(), $urandom);
		if (whole) steps = (plan_count < plan_last) ? plan_last - plan_count : 1;
		else steps = $urandom_range(40, 1);
		repeat (steps) begin
			if ($urandom_range(15, 0) == 0) stray_item();
			push_item(MODE_STEP, rand_idx(), rand_idx(), $urandom);
		end
	endfunction

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_INNER_COUNT: reg_inner = value[REG_W-1:0];
		REG_OUTER_COUNT: reg_outer = value[REG_W-1:0];
		REG_PREFIX_VALUE: reg_prefix = value[PFX_W-1:0];
		default: ;
		endcase
	endtask

	// Waits until every item is taken and every result is back, then lets
	// any trailing loads or pass correction finish.
	task automatic settle();
		while (stimulus_items.size() != 0 || expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : sequencer
		int inner_sel;
		int outer_sel;
		logic [PFX_W-1:0] pfx;
		// A real falling edge on reset, so the asynchronous reset takes hold at once.
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset configuration: sixteen inner variables.
		reload_system(16);
		push_item(MODE_LOAD_CONST, 4'hF, 4'hF, '0);
		push_item(MODE_START, '0, '0, '1);
		push_item(MODE_STEP, 4'hF, 4'hF, '1);
		push_item(MODE_STEP, '0, '0, '0);
		push_item(MODE_LOAD_QUAD, 4'hF, 4'hF, '1);
		push_item(MODE_LOAD_QUAD, 4'h0, 4'hF, '0);
		push_item(MODE_LOAD_LIN, 4'hF, 4'h0, '0);
		push_item(MODE_LOAD_CONST, '0, 4'hF, '1);
		for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) begin
			push_item(MODE_W'(m), 4'hF, 4'hF, '1);
		end
		// A restart in the middle of a pass keeps the counter.
		push_item(MODE_START, 4'hF, 4'h0, '0);
		push_item(MODE_STEP, 4'h0, 4'hF, '1);
		push_item(MODE_STEP, 4'hA, 4'h5, 32'h5555_AAAA);
		settle();

		for (int phase = 0; counted_items < ITEM_TARGET; phase++) begin
			case (phase)
			0: begin
				inner_sel = 0;
				outer_sel = 31;
				pfx = '1;
			end
			1: begin
				inner_sel = 1;
				outer_sel = 16;
				pfx = '0;
			end
			2: begin
				inner_sel = 31;
				outer_sel = 0;
				pfx = 16'h5A5A;
			end
			3: begin
				inner_sel = 6;
				outer_sel = 17;
				pfx = PFX_W'($urandom);
			end
			default: begin
				inner_sel = ($urandom_range(7, 0) == 0) ? $urandom_range(31, 7) : $urandom_range(6, 0);
				outer_sel = $urandom_range(31, 0);
				pfx = PFX_W'($urandom);
			end
			endcase
			write_reg(REG_INNER_COUNT, CFG_DATA_W'(inner_sel));
			write_reg(REG_OUTER_COUNT, CFG_DATA_W'(outer_sel));
			write_reg(REG_PREFIX_VALUE, pfx);
			plan_vars = inner_vars();
			plan_last = (1 << plan_vars) - 1;
			calm = (counted_items > ITEM_TARGET - CALM_ITEMS);
			bursty_in = ($urandom_range(2, 0) != 0);
			bursty_out = ($urandom_range(2, 0) != 0);
			// Sparse words over one or two equations make zero values common.
			sparse = (plan_vars <= 7) && (phase < 2 || $urandom_range(2, 0) != 0);
			if (sparse) word_mask = (32'd1 << $urandom_range(31, 0)) | (32'd1 << $urandom_range(31, 0));
			else word_mask = '1;
			repeat ($urandom_range(3, 1)) begin
				if (sparse) reload_system(plan_vars);
				run_pass(plan_vars <= 7);
			end
			settle();
		end

		if (errors == 0) $display("PASS gf2_quadratic_gray_enumerator");
		else $display("FAIL gf2_quadratic_gray_enumerator");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("FAIL gf2_quadratic_gray_enumerator");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/gqge_pkg.sv
sv/gqge_front.sv
sv/gqge_fifo.sv
sv/gqge_back.sv
sv/gf2_quadratic_gray_enumerator.sv
sv/gqge_checker.sv
bench/tb_top.sv
